>>> rtl/bve_pkg.sv
// Package for the byte VM execute unit: widths, opcodes and the structs between modules.
`timescale 1ns / 1ps
`default_nettype none

package bve_pkg;

   // Widths and sizes
   localparam int NumRegs  = 16;
   localparam int RegIdxW  = 4;
   localparam int DataW    = 8;
   localparam int PcW      = 8;
   localparam logic [PcW-1:0] PcStep = 8'h02;

   // Opcodes
   localparam logic [7:0] OP_INC   = 8'h01;
   localparam logic [7:0] OP_DEC   = 8'h02;
   localparam logic [7:0] OP_MOV   = 8'h03;
   localparam logic [7:0] OP_LDI   = 8'h04;
   localparam logic [7:0] OP_SHL   = 8'h05;
   localparam logic [7:0] OP_SHR   = 8'h06;
   localparam logic [7:0] OP_JMP   = 8'h07;
   localparam logic [7:0] OP_JEND  = 8'h0A;
   localparam logic [7:0] OP_HALT  = 8'h0B;
   localparam logic [7:0] OP_ADD   = 8'h0C;
   localparam logic [7:0] OP_SUB   = 8'h0D;
   localparam logic [7:0] OP_XOR   = 8'h0E;
   localparam logic [7:0] OP_OR    = 8'h0F;
   localparam logic [7:0] OP_READ  = 8'h10;
   localparam logic [7:0] OP_EMIT  = 8'h11;

   // One instruction as held in the input register
   typedef struct packed {
      logic [7:0]       command;
      logic [7:0]       operand;
      logic [DataW-1:0] in_byte;
      logic             in_end;
   } item_type;

   // Everything the execute logic looks at
   typedef struct packed {
      item_type         item;
      logic [DataW-1:0] rd_d;
      logic [DataW-1:0] rd_s;
      logic [PcW-1:0]   pc;
      logic             end_seen;
      logic             stopped;
   } exec_in_type;

   // Everything the execute logic decides
   typedef struct packed {
      logic             reg_we;
      logic [DataW-1:0] reg_wdata;
      logic [PcW-1:0]   next_pc;
      logic [DataW-1:0] out_byte;
      logic             out_valid;
      logic             halted;
      logic             set_end;
   } exec_out_type;

endpackage

`default_nettype wire

>>> rtl/bve_if.sv
// Channel interfaces for the byte VM execute unit: instruction in, result out.
`timescale 1ns / 1ps
`default_nettype none

interface bve_req_if;
   logic                     valid;
   logic                     ready;
   logic [7:0]               command;
   logic [7:0]               operand;
   logic [bve_pkg::DataW-1:0] in_byte;
   logic                     in_end;

   modport source (output valid, command, operand, in_byte, in_end, input ready);
   modport sink   (input valid, command, operand, in_byte, in_end, output ready);
endinterface

interface bve_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [bve_pkg::PcW-1:0]   next_pc;
   logic [bve_pkg::DataW-1:0] out_byte;
   logic                      out_valid;
   logic                      halted;

   modport source (output valid, next_pc, out_byte, out_valid, halted, input ready);
   modport sink   (input valid, next_pc, out_byte, out_valid, halted, output ready);
endinterface

`default_nettype wire

>>> rtl/bve_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module bve_ram #(
   parameter int Width = 8,
   parameter int Depth = 16,
   localparam int AddrW = $clog2(Depth)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AddrW-1:0] waddr,
   input  wire logic [Width-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AddrW-1:0] raddr_a,
   input  wire logic [AddrW-1:0] raddr_b,
   output logic      [Width-1:0] rdata_a,
   output logic      [Width-1:0] rdata_b
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_a_ff;
   logic [Width-1:0] rdata_b_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read ports, held while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_a_ff <= mem_ff[raddr_a];
         rdata_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

`default_nettype wire

>>> rtl/bve_exec.sv
// Execute logic: decodes one instruction and works out register write, pc and result.
`timescale 1ns / 1ps
`default_nettype none

module bve_exec (
   input  wire bve_pkg::exec_in_type  exec_in,
   output bve_pkg::exec_out_type      exec_out
);

   logic [bve_pkg::PcW-1:0] pc_step;
   logic [bve_pkg::PcW-1:0] pc_jump;

   // Both pc candidates; the operand added modulo 256 acts as a signed offset
   assign pc_step = exec_in.pc + bve_pkg::PcStep;
   assign pc_jump = exec_in.pc + exec_in.item.operand;

   always_comb begin
      exec_out           = '0;
      exec_out.next_pc   = pc_step;
      exec_out.halted    = 1'b0;
      if (exec_in.stopped) begin
         // After halt: nothing changes, pc repeats
         exec_out.next_pc = exec_in.pc;
         exec_out.halted  = 1'b1;
      end else begin
         unique case (exec_in.item.command)
            bve_pkg::OP_INC: begin
               exec_out.reg_we    = 1'b1;
               exec_out.reg_wdata = exec_in.rd_d + 8'd1;
            end
            bve_pkg::OP_DEC: begin
               exec_out.reg_we    = 1'b1;
               exec_out.reg_wdata = exec_in.rd_d - 8'd1;
            end
            bve_pkg::OP_MOV: begin
               exec_out.reg_we    = 1'b1;
               exec_out.reg_wdata = exec_in.rd_s;
            end
            bve_pkg::OP_LDI: begin
               exec_out.reg_we    = 1'b1;
               exec_out.reg_wdata = exec_in.item.operand;
            end
            bve_pkg::OP_SHL: begin
               exec_out.reg_we    = 1'b1;
               exec_out.reg_wdata = {exec_in.rd_d[6:0], 1'b0};
            end
            bve_pkg::OP_SHR: begin
               exec_out.reg_we    = 1'b1;
               exec_out.reg_wdata = {1'b0, exec_in.rd_d[7:1]};
            end
            bve_pkg::OP_JMP: begin
               exec_out.next_pc = pc_jump;
            end
            bve_pkg::OP_JEND: begin
               if (exec_in.end_seen) begin
                  exec_out.next_pc = pc_jump;
               end
            end
            bve_pkg::OP_HALT: begin
               exec_out.halted = 1'b1;
            end
            bve_pkg::OP_ADD: begin
               exec_out.reg_we    = 1'b1;
               exec_out.reg_wdata = exec_in.rd_d + exec_in.rd_s;
            end
            bve_pkg::OP_SUB: begin
               exec_out.reg_we    = 1'b1;
               exec_out.reg_wdata = exec_in.rd_d - exec_in.rd_s;
            end
            bve_pkg::OP_XOR: begin
               exec_out.reg_we    = 1'b1;
               exec_out.reg_wdata = exec_in.rd_d ^ exec_in.rd_s;
            end
            bve_pkg::OP_OR: begin
               exec_out.reg_we    = 1'b1;
               exec_out.reg_wdata = exec_in.rd_d | exec_in.rd_s;
            end
            bve_pkg::OP_READ: begin
               // End of input latches the flag, otherwise take the byte
               if (exec_in.item.in_end) begin
                  exec_out.set_end = 1'b1;
               end else begin
                  exec_out.reg_we    = 1'b1;
                  exec_out.reg_wdata = exec_in.item.in_byte;
               end
            end
            bve_pkg::OP_EMIT: begin
               exec_out.out_byte  = exec_in.rd_d;
               exec_out.out_valid = 1'b1;
            end
            default: begin
               // Unknown opcode: pc advances only
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/byte_vm_execute_unit_top.sv
// Top level of the byte VM execute unit: input register, register file, result register.
//
//   channel  direction  transaction
//   req_chan in         command, operand, in_byte, in_end (one instruction)
//   rsp_chan out        next_pc, out_byte, out_valid, halted (one result per instruction)
//
// One instruction per cycle while rsp is taken; each passes input register, then result register.
// The register file RAM is read as the instruction enters the input register; a write by the
// instruction retiring in that same cycle is forwarded. Execution and the state update happen
// as the result register loads. Reset is synchronous and clears pc, flags and register valid
// bits (unwritten registers read as zero). A stalled rsp holds the input register; req_ready
// drops only when both registers are full and rsp is not taken.
`timescale 1ns / 1ps
`default_nettype none

module byte_vm_execute_unit_top (
   input  wire logic clock,
   input  wire logic reset,
   bve_req_if.sink   req_chan,
   bve_rsp_if.source rsp_chan
);

   localparam int RegIdxW = bve_pkg::RegIdxW;
   localparam int DataW   = bve_pkg::DataW;
   localparam int NumRegs = bve_pkg::NumRegs;

   // Input register
   logic                  in_valid_ff, in_valid_in;
   bve_pkg::item_type     item_ff;
   // Architectural state
   logic [bve_pkg::PcW-1:0] pc_ff, pc_in;
   logic                  end_seen_ff, end_seen_in;
   logic                  stopped_ff, stopped_in;
   logic [NumRegs-1:0]    reg_vld_ff, reg_vld_in;
   // Read-side bookkeeping captured with the item
   logic                  vld_d_ff, vld_s_ff;
   logic                  fwd_d_ff, fwd_s_ff;
   logic [DataW-1:0]      fwd_data_ff;
   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [bve_pkg::PcW-1:0] rsp_pc_ff;
   logic [DataW-1:0]      rsp_byte_ff;
   logic                  rsp_out_valid_ff;
   logic                  rsp_halted_ff;

   logic                  fire;
   logic                  req_ready;
   logic                  accept;
   logic                  reg_we;
   logic [RegIdxW-1:0]    waddr;
   logic [RegIdxW-1:0]    raddr_d;
   logic [RegIdxW-1:0]    raddr_s;
   logic [DataW-1:0]      ram_d;
   logic [DataW-1:0]      ram_s;
   bve_pkg::exec_in_type  exec_in;
   bve_pkg::exec_out_type exec_out;

   // Handshake
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_ready = !in_valid_ff || fire;
   assign accept    = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   assign raddr_d = req_chan.operand[RegIdxW-1:0];
   assign raddr_s = req_chan.operand[2*RegIdxW-1:RegIdxW];
   assign waddr   = item_ff.operand[RegIdxW-1:0];
   assign reg_we  = fire && exec_out.reg_we;

   // Register file
   bve_ram #(
      .Width (DataW),
      .Depth (NumRegs)
   ) u_regfile (
      .clock   (clock),
      .we      (reg_we),
      .waddr   (waddr),
      .wdata   (exec_out.reg_wdata),
      .re      (accept),
      .raddr_a (raddr_d),
      .raddr_b (raddr_s),
      .rdata_a (ram_d),
      .rdata_b (ram_s)
   );

   // Operand selection: forwarded write, else stored value, else reset value
   always_comb begin
      exec_in          = '0;
      exec_in.item     = item_ff;
      exec_in.pc       = pc_ff;
      exec_in.end_seen = end_seen_ff;
      exec_in.stopped  = stopped_ff;
      exec_in.rd_d     = fwd_d_ff ? fwd_data_ff : (vld_d_ff ? ram_d : '0);
      exec_in.rd_s     = fwd_s_ff ? fwd_data_ff : (vld_s_ff ? ram_s : '0);
   end

   bve_exec u_exec (
      .exec_in  (exec_in),
      .exec_out (exec_out)
   );

   // Next-state logic
   always_comb begin
      in_valid_in  = in_valid_ff;
      pc_in        = pc_ff;
      end_seen_in  = end_seen_ff;
      stopped_in   = stopped_ff;
      reg_vld_in   = reg_vld_ff;
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         in_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         pc_in        = exec_out.next_pc;
         end_seen_in  = end_seen_ff || exec_out.set_end;
         stopped_in   = exec_out.halted;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (reg_we) begin
         reg_vld_in[waddr] = 1'b1;
      end
      if (accept) begin
         in_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         end_seen_ff  <= 1'b0;
         stopped_ff   <= 1'b0;
         reg_vld_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
         end_seen_ff  <= end_seen_in;
         stopped_ff   <= stopped_in;
         reg_vld_ff   <= reg_vld_in;
      end
   end

   // Input register payload and read bookkeeping
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.command <= req_chan.command;
         item_ff.operand <= req_chan.operand;
         item_ff.in_byte <= req_chan.in_byte;
         item_ff.in_end  <= req_chan.in_end;
         vld_d_ff        <= reg_vld_ff[raddr_d];
         vld_s_ff        <= reg_vld_ff[raddr_s];
         fwd_d_ff        <= reg_we && (waddr == raddr_d);
         fwd_s_ff        <= reg_we && (waddr == raddr_s);
         fwd_data_ff     <= exec_out.reg_wdata;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_pc_ff        <= exec_out.next_pc;
         rsp_byte_ff      <= exec_out.out_byte;
         rsp_out_valid_ff <= exec_out.out_valid;
         rsp_halted_ff    <= exec_out.halted;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.next_pc   = rsp_pc_ff;
   assign rsp_chan.out_byte  = rsp_byte_ff;
   assign rsp_chan.out_valid = rsp_out_valid_ff;
   assign rsp_chan.halted    = rsp_halted_ff;

endmodule

`default_nettype wire
